/* hdl/hmpq_pkg.sv */
// shared types and constants of the max heap priority queue
package hmpq_pkg;

    // default number of stored values
    localparam int CAPACITY = 128;

    // data and field widths
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 8;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // command broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } t_cell_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     take;
        logic signed [DATA_W-1:0] value;
    } t_cell_link;

endpackage

/* hdl/hmpq_cell.sv */
// one slot of the sorted cell chain, largest value at the head
module hmpq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hmpq_pkg::t_cell_cmd   i_cmd,
    input  hmpq_pkg::t_cell_link  i_left,
    input  hmpq_pkg::t_cell_link  i_right,
    output hmpq_pkg::t_cell_link  o_link
);

    logic                              r_valid;
    logic signed [hmpq_pkg::DATA_W-1:0] r_value;
    logic                              n_valid;
    logic signed [hmpq_pkg::DATA_W-1:0] n_value;
    logic                              w_take;

    // new word belongs here or further up the chain
    assign w_take = !r_valid || (i_cmd.value > r_value);

    // insert shifts toward the tail, remove shifts toward the head
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_cmd.ins) begin
            if (i_left.take) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else if (w_take) begin
                n_valid = 1'b1;
                n_value = i_cmd.value;
            end
        end else if (i_cmd.rem) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    // occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // stored value
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid = r_valid;
    assign o_link.take  = w_take;
    assign o_link.value = r_value;

endmodule

/* hdl/max_heap_priority_queue.sv */
// top level of the max priority queue built as a chain of sorted cells
//
// Input channel: i_valid / o_ready carry one word: i_func (0 insert i_value,
// 1 remove the maximum) and i_value. Output channel: o_valid / i_ready carry
// one result word per input word: o_max_value (the maximum after the
// operation, -1 when empty), o_is_empty, o_count and o_status (0 done,
// 1 insert dropped because full, 2 remove dropped because empty).
// Storage is a row of CAPACITY identical cells kept sorted largest first;
// every cell compares the incoming value with its own in parallel and
// shifts one place, so any operation completes in the cycle it is accepted.
// The result passes from the pending-result slot into the output register,
// and no new word is accepted while that single pending-result slot is
// full, so the next word waits until the pending result has moved on.
// While the receiver holds i_ready low the result waits in the output
// register and at most one further word is taken and held pending.
// Reset (i_rst_n low, synchronous) empties the queue at once; no clearing
// pass is needed.
module max_heap_priority_queue #(
    parameter int CAPACITY = hmpq_pkg::CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_func,
    input  logic signed [hmpq_pkg::DATA_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [hmpq_pkg::DATA_W-1:0]  o_max_value,
    output logic                                o_is_empty,
    output logic [hmpq_pkg::COUNT_W-1:0]        o_count,
    output logic [1:0]                          o_status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    hmpq_pkg::t_cell_cmd  w_cmd;
    hmpq_pkg::t_cell_link w_link [CAPACITY];
    hmpq_pkg::t_cell_link w_head_link;
    hmpq_pkg::t_cell_link w_tail_link;
    logic [CAPACITY-1:0]  w_valid_vec;

    logic                               w_accept;
    logic                               w_full;
    logic                               w_none;
    logic                               w_load;
    logic [CW+hmpq_pkg::COUNT_W-1:0]    w_count_ext;

    logic [CW-1:0]                      r_count;
    logic                               r_pend;
    hmpq_pkg::t_status                  r_status;
    logic                               r_out_valid;
    logic signed [hmpq_pkg::DATA_W-1:0] r_max;
    logic                               r_empty;
    logic [hmpq_pkg::COUNT_W-1:0]       r_cnt_out;
    hmpq_pkg::t_status                  r_st_out;

    // input handshake and operation decode
    assign o_ready  = !r_pend;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CAP_CNT);
    assign w_none   = (r_count == '0);

    assign w_cmd.ins   = w_accept && (i_func == hmpq_pkg::FUNC_INSERT) && !w_full;
    assign w_cmd.rem   = w_accept && (i_func == hmpq_pkg::FUNC_REMOVE) && !w_none;
    assign w_cmd.value = i_value;

    // chain ends: nothing enters from above the head, empty slot below tail
    assign w_head_link.valid = 1'b0;
    assign w_head_link.take  = 1'b0;
    assign w_head_link.value = '0;
    assign w_tail_link.valid = 1'b0;
    assign w_tail_link.take  = 1'b0;
    assign w_tail_link.value = '0;

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        hmpq_pkg::t_cell_link w_left;
        hmpq_pkg::t_cell_link w_right;
        if (g == 0) begin : g_head
            assign w_left = w_head_link;
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_tail_link;
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end
        hmpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[g])
        );
        assign w_valid_vec[g] = w_link[g].valid;
    end

    // element count and pending result status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_status <= hmpq_pkg::ST_DONE;
        end else begin
            if (w_cmd.ins) begin
                r_count <= r_count + CW'(1);
            end else if (w_cmd.rem) begin
                r_count <= r_count - CW'(1);
            end
            if (w_accept) begin
                r_pend <= 1'b1;
                if (i_func == hmpq_pkg::FUNC_INSERT) begin
                    r_status <= w_full ? hmpq_pkg::ST_FULL : hmpq_pkg::ST_DONE;
                end else begin
                    r_status <= w_none ? hmpq_pkg::ST_EMPTY : hmpq_pkg::ST_DONE;
                end
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
        end
    end

    // output register
    assign w_load      = r_pend && (!r_out_valid || i_ready);
    assign w_count_ext = {{hmpq_pkg::COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_max     <= w_none ? -32'sd1 : w_link[0].value;
            r_empty   <= w_none;
            r_cnt_out <= w_count_ext[hmpq_pkg::COUNT_W-1:0];
            r_st_out  <= r_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_max_value = r_max;
    assign o_is_empty  = r_empty;
    assign o_count     = r_cnt_out;
    assign o_status    = r_st_out;

    // occupied cells always match the element count
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid_vec) == int'(r_count))
        else $error("occupied cells differ from element count");

    // the chain stays sorted at its head
    if (CAPACITY > 1) begin : g_sort_chk
        a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (w_link[0].valid && w_link[1].valid) |-> (w_link[0].value >= w_link[1].value))
            else $error("head cells out of order");
    end

    // an insert into a non-full queue places its value at or below the head
    a_insert_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ins |=> (w_link[0].valid && (w_link[0].value >= $past(i_value))))
        else $error("inserted value exceeds the head");

    // a pending result leaves no room for a new word
    a_one_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !w_load) |=> r_pend && $stable(r_count))
        else $error("pending result lost or state changed while pending");

endmodule

/* tb/max_heap_result_checker.sv */
// result checker for the max heap priority queue: heap predictor and field compare
module max_heap_result_checker #(
    parameter int CAPACITY = hmpq_pkg::CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_func,
    input  logic signed [hmpq_pkg::DATA_W-1:0]  i_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [hmpq_pkg::DATA_W-1:0]  i_max_value,
    input  logic                                i_is_empty,
    input  logic [hmpq_pkg::COUNT_W-1:0]        i_count,
    input  logic [1:0]                          i_status,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    // one predicted result word
    typedef struct packed {
        logic signed [hmpq_pkg::DATA_W-1:0] max_value;
        logic                               is_empty;
        logic [hmpq_pkg::COUNT_W-1:0]       count;
        hmpq_pkg::t_status                  status;
    } t_queue_result;

    // predicted heap contents
    logic signed [hmpq_pkg::DATA_W-1:0] heap_mem [CAPACITY];
    int unsigned                        heap_size = 0;

    t_queue_result expected_results [$];
    t_queue_result exp_res;
    int            fail_count = 0;

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        logic signed [hmpq_pkg::DATA_W-1:0] tmp;
        tmp         = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = tmp;
    endfunction

    // apply one word to the predicted heap and return the result it should produce
    function automatic t_queue_result heap_apply_op(
            input logic                               func,
            input logic signed [hmpq_pkg::DATA_W-1:0] value);
        int unsigned   pos;
        int unsigned   parent;
        int unsigned   l_child;
        int unsigned   r_child;
        int unsigned   best;
        logic          settled;
        t_queue_result res;
        res.status = hmpq_pkg::ST_DONE;
        if (func == hmpq_pkg::FUNC_INSERT) begin
            if (heap_size >= CAPACITY) begin
                res.status = hmpq_pkg::ST_FULL;
            end else begin
                // sift up while the parent is strictly smaller
                heap_mem[heap_size] = value;
                pos     = heap_size;
                settled = 1'b0;
                while (pos > 0 && !settled) begin
                    parent = (pos - 1) / 2;
                    if (heap_mem[parent] < heap_mem[pos]) begin
                        swap_slots(parent, pos);
                        pos = parent;
                    end else begin
                        settled = 1'b1;
                    end
                end
                heap_size++;
            end
        end else if (heap_size == 0) begin
            res.status = hmpq_pkg::ST_EMPTY;
        end else begin
            // last element to the root, then sift down toward the larger child
            heap_mem[0] = heap_mem[heap_size - 1];
            heap_size--;
            pos     = 0;
            settled = 1'b0;
            while (!settled) begin
                l_child = 2 * pos + 1;
                r_child = l_child + 1;
                best    = pos;
                if (l_child < heap_size && heap_mem[l_child] > heap_mem[best])
                    best = l_child;
                if (r_child < heap_size && heap_mem[r_child] > heap_mem[best])
                    best = r_child;
                if (best == pos) begin
                    settled = 1'b1;
                end else begin
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        end
        res.max_value = (heap_size == 0) ? -32'sd1 : heap_mem[0];
        res.is_empty  = (heap_size == 0);
        res.count     = hmpq_pkg::COUNT_W'(heap_size);
        return res;
    endfunction

    // compare each result word with the oldest prediction, then predict new words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            heap_size = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word max=%0d empty=%0b count=%0d status=%0d",
                             $time, i_max_value, i_is_empty, i_count, i_status);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_max_value !== exp_res.max_value) begin
                        $display("%0t: max_value expected %0d actual %0d",
                                 $time, exp_res.max_value, i_max_value);
                        fail_count++;
                    end
                    if (i_is_empty !== exp_res.is_empty) begin
                        $display("%0t: is_empty expected %0b actual %0b",
                                 $time, exp_res.is_empty, i_is_empty);
                        fail_count++;
                    end
                    if (i_count !== exp_res.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, exp_res.count, i_count);
                        fail_count++;
                    end
                    if (i_status !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, i_status);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(heap_apply_op(i_func, i_value));
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_results.size();
    end

endmodule

/* tb/tb_max_heap_priority_queue.sv */
// testbench top for the max heap priority queue: stimulus, handshake idling and verdict
module tb_max_heap_priority_queue;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int MAX_GAP         = 12;
    localparam int RANDOM_WORDS    = 1400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 20;

    // stimulus phase kinds
    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_HOVER
    } t_phase;

    logic                               i_clk   = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               i_func  = hmpq_pkg::FUNC_INSERT;
    logic signed [hmpq_pkg::DATA_W-1:0] i_value = '0;
    logic                               i_ready = 1'b0;
    logic                               o_ready;
    logic                               o_valid;
    logic signed [hmpq_pkg::DATA_W-1:0] o_max_value;
    logic                               o_is_empty;
    logic [hmpq_pkg::COUNT_W-1:0]       o_count;
    logic [1:0]                         o_status;

    int   fail_count;
    int   pending;
    int   idle_cycles  = 0;
    logic no_idle      = 1'b0;
    logic hold_request = 1'b0;

    max_heap_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_max_value (o_max_value),
        .o_is_empty  (o_is_empty),
        .o_count     (o_count),
        .o_status    (o_status)
    );

    max_heap_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_func       (i_func),
        .i_value      (i_value),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_max_value  (o_max_value),
        .i_is_empty   (o_is_empty),
        .i_count      (o_count),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // half full-range values, many small ones for ties, some extremes
    function automatic logic signed [hmpq_pkg::DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return $urandom;
        if (sel < 85)
            return int'($urandom_range(0, 6)) - 3;
        case ($urandom_range(0, 4))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic func,
                             input logic signed [hmpq_pkg::DATA_W-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // stop offering until every predicted result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // receiver side: random stalls per word and one long hold-off
    initial begin
        int stall;
        forever begin
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_max_heap_priority_queue NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // sender side and verdict
    initial begin
        int     words_sent;
        int     phase_idx;
        int     phase_len;
        int     insert_pct;
        t_phase phase;
        words_sent = 0;
        phase_idx  = 0;
        phase      = PH_FILL;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty removes, extremes, ties, drain past empty
        send_word(hmpq_pkg::FUNC_REMOVE, 32'sh0);
        send_word(hmpq_pkg::FUNC_REMOVE, -32'sd1);
        send_word(hmpq_pkg::FUNC_INSERT, -32'sd1);
        send_word(hmpq_pkg::FUNC_REMOVE, 32'sh5555_5555);
        send_word(hmpq_pkg::FUNC_INSERT, 32'sh8000_0000);
        send_word(hmpq_pkg::FUNC_INSERT, -32'sd1);
        send_word(hmpq_pkg::FUNC_INSERT, 32'sh7FFF_FFFF);
        send_word(hmpq_pkg::FUNC_INSERT, 32'sh0);
        send_word(hmpq_pkg::FUNC_INSERT, 32'sd5);
        send_word(hmpq_pkg::FUNC_INSERT, 32'sd5);
        send_word(hmpq_pkg::FUNC_INSERT, 32'sd5);
        send_word(hmpq_pkg::FUNC_INSERT, 32'sh7FFF_FFFF);
        repeat (8) send_word(hmpq_pkg::FUNC_REMOVE, pick_value());
        send_word(hmpq_pkg::FUNC_REMOVE, 32'shAAAA_AAAA);
        wait_drained();

        // random phases: fill to full, drain to empty, then a mix
        while (words_sent < RANDOM_WORDS) begin
            case (phase_idx)
                0: phase = PH_FILL;
                1: phase = PH_DRAIN;
                default: phase = t_phase'($urandom_range(0, 3));
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            // receiver holds off while words keep coming so the input stalls
            if (phase_idx == 2)
                hold_request = 1'b1;
            case (phase)
                PH_FILL: begin
                    insert_pct = 90;
                    phase_len  = $urandom_range(170, 220);
                end
                PH_DRAIN: begin
                    insert_pct = 10;
                    phase_len  = $urandom_range(170, 220);
                end
                PH_MIXED: begin
                    insert_pct = 50;
                    phase_len  = $urandom_range(40, 120);
                end
                default: begin
                    insert_pct = 60;
                    phase_len  = $urandom_range(60, 150);
                end
            endcase
            repeat (phase_len) begin
                send_word(($urandom_range(0, 99) < insert_pct) ?
                              hmpq_pkg::FUNC_INSERT : hmpq_pkg::FUNC_REMOVE,
                          pick_value());
                words_sent++;
            end
            if (phase_idx == 1 || $urandom_range(0, 2) == 0)
                wait_drained();
            phase_idx++;
        end

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_max_heap_priority_queue OK");
        end else begin
            if (pending != 0)
                $display("%0t: %0d expected result words never arrived", $time, pending);
            $display("tb_max_heap_priority_queue NOT OK");
        end
        $finish;
    end

endmodule
